// File: design/bn_pkg.sv
package bn_pkg;

  localparam int MAX_CHANNELS = 4096;
  localparam int CH_W         = $clog2(MAX_CHANNELS);
  localparam int NUM_CH_W     = 13;
  localparam int DATA_W       = 32;
  localparam int EPS_W        = 16;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 16;

  localparam int DEN_W      = 33;
  localparam int QUO_W      = 49;
  localparam int SRC_W      = 50;
  localparam int ROOT_W     = 25;
  localparam int SQ_REM_W   = 26;
  localparam int STEP_W     = 6;

  localparam logic [ROOT_W-1:0] INV_STD_MAX = 25'h100_0000;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NUM_CHANNELS,
    REG_USE_GAMMA,
    REG_USE_BETA,
    REG_EPSILON
  } cfg_reg_t;

  typedef enum logic [1:0] {
    RS_IDLE,
    RS_DIV,
    RS_SQRT,
    RS_DONE
  } rsqrt_state_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] mean;
    logic        [DATA_W-1:0] inv_std;
    logic signed [DATA_W-1:0] gamma;
    logic signed [DATA_W-1:0] beta;
  } bn_param_t;

  typedef struct packed {
    logic [NUM_CH_W-1:0] num_channels;
    logic                use_gamma;
    logic                use_beta;
  } bn_cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rsqrt_status_t;

  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    if (v > 49'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (v < -49'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

// File: design/batchnorm_inference_affine.sv
// Batch normalization for inference on signed Q16.16 data.
// Input channel: in_valid / in_stall with fields cmd, channel_index, sample_value
// and the load_* parameters. Output channel: out_valid / out_stall with
// result_value, result_channel and error_code. A transaction moves on a rising
// edge with valid high and stall low.
// A sample transaction (cmd 0) gives one result; samples stream at one per
// cycle, while in_stall is low, through a seven-register pipeline with two
// 32-bit-class multipliers. Channels at or above num_channels return 0 with
// error_code 1.
// A load transaction (cmd 1) gives no result. It stores mean, gamma, beta and
// 1/sqrt(var + epsilon) for the channel; the inverse root comes from a bit-serial
// divider followed by a bit-serial square root. in_stall stays high after a load
// until its parameters are written; both steps are skipped for var + epsilon 0.
// Parameter memory is not cleared; read a channel only after loading.
// Reset: the pipeline empties, the divider goes idle and the registers return
// to num_channels 1, use_gamma 1, use_beta 1, epsilon 1.
// When out_stall is high the output register holds its result; the stages
// behind it keep filling their empty slots, then in_stall rises.
// Registers are written through cfg_write_en / cfg_index / cfg_data; the user
// must write them only while the block is idle, which the block does not enforce.
module batchnorm_inference_affine (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_en,
  input  logic [bn_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [bn_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                cmd,
  input  logic [bn_pkg::CH_W-1:0]             channel_index,
  input  logic signed [bn_pkg::DATA_W-1:0]    sample_value,
  input  logic signed [bn_pkg::DATA_W-1:0]    load_mean,
  input  logic [bn_pkg::DATA_W-1:0]           load_var,
  input  logic signed [bn_pkg::DATA_W-1:0]    load_gamma,
  input  logic signed [bn_pkg::DATA_W-1:0]    load_beta,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [bn_pkg::DATA_W-1:0]    result_value,
  output logic [bn_pkg::CH_W-1:0]             result_channel,
  output logic                                error_code
);
  import bn_pkg::*;

  bn_cfg_t                  cfg;
  logic [EPS_W-1:0]         epsilon;
  logic                     pipe_ready;
  logic                     load_take;
  logic                     sample_take;
  logic [DEN_W-1:0]         den;
  rsqrt_status_t            rs_status;
  logic [DATA_W-1:0]        inv_std;
  logic [CH_W-1:0]          ld_ch;
  logic signed [DATA_W-1:0] ld_mean;
  logic signed [DATA_W-1:0] ld_gamma;
  logic signed [DATA_W-1:0] ld_beta;
  bn_param_t                wr_param;
  bn_param_t                rd_param;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_channels <= NUM_CH_W'(1);
      cfg.use_gamma    <= 1'b1;
      cfg.use_beta     <= 1'b1;
      epsilon          <= EPS_W'(1);
    end else if (cfg_write_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_NUM_CHANNELS: cfg.num_channels <= cfg_data[NUM_CH_W-1:0];
        REG_USE_GAMMA:    cfg.use_gamma    <= cfg_data[0];
        REG_USE_BETA:     cfg.use_beta     <= cfg_data[0];
        REG_EPSILON:      epsilon          <= cfg_data[EPS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall    = rs_status.busy || !pipe_ready;
  assign load_take   = in_valid && !in_stall && (cmd == CMD_LOAD);
  assign sample_take = in_valid && !in_stall && (cmd == CMD_SAMPLE);
  assign den         = {1'b0, load_var} + {{(DEN_W - EPS_W){1'b0}}, epsilon};

  always_ff @(posedge clk) begin
    if (load_take) begin
      ld_ch    <= channel_index;
      ld_mean  <= load_mean;
      ld_gamma <= load_gamma;
      ld_beta  <= load_beta;
    end
  end

  assign wr_param.mean    = ld_mean;
  assign wr_param.inv_std = inv_std;
  assign wr_param.gamma   = ld_gamma;
  assign wr_param.beta    = ld_beta;

  bn_rsqrt u_rsqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (load_take),
    .den     (den),
    .status  (rs_status),
    .inv_std (inv_std)
  );

  bn_param_store u_store (
    .clk     (clk),
    .wr_en   (rs_status.done),
    .wr_addr (ld_ch),
    .wr_data (wr_param),
    .rd_en   (pipe_ready),
    .rd_addr (channel_index),
    .rd_data (rd_param)
  );

  bn_norm_pipe u_pipe (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .take           (sample_take),
    .channel_index  (channel_index),
    .sample_value   (sample_value),
    .ready          (pipe_ready),
    .param          (rd_param),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_value   (result_value),
    .result_channel (result_channel),
    .error_code     (error_code)
  );

`ifndef ASSERT_OFF
  a_load_blocks: assert property (@(posedge clk) disable iff (rst)
    load_take |=> in_stall)
    else $error("input taken right after a load");

  a_write_no_take: assert property (@(posedge clk) disable iff (rst)
    rs_status.done |-> !(in_valid && !in_stall))
    else $error("transaction taken during parameter write");
`endif

endmodule

// File: design/bn_rsqrt.sv
module bn_rsqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [bn_pkg::DEN_W-1:0]  den,
  output bn_pkg::rsqrt_status_t     status,
  output logic [bn_pkg::DATA_W-1:0] inv_std
);
  import bn_pkg::*;

  rsqrt_state_t        state, state_next;
  logic [STEP_W-1:0]   cnt, cnt_next;
  logic [DEN_W-1:0]    dvsr, dvsr_next;
  logic [DEN_W-1:0]    rem, rem_next;
  logic [QUO_W-1:0]    quo, quo_next;
  logic [SRC_W-1:0]    src, src_next;
  logic [SQ_REM_W-1:0] sq_rem, sq_rem_next;
  logic [ROOT_W-1:0]   root, root_next;
  logic [DEN_W:0]      shifted;
  logic [SQ_REM_W+1:0] acc;
  logic [SQ_REM_W+1:0] trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RS_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
    dvsr   <= dvsr_next;
    rem    <= rem_next;
    quo    <= quo_next;
    src    <= src_next;
    sq_rem <= sq_rem_next;
    root   <= root_next;
  end

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    dvsr_next   = dvsr;
    rem_next    = rem;
    quo_next    = quo;
    src_next    = src;
    sq_rem_next = sq_rem;
    root_next   = root;
    shifted     = {rem, (cnt == STEP_W'(QUO_W - 1))};
    acc         = {sq_rem, src[SRC_W-1 -: 2]};
    trial       = {1'b0, root, 2'b01};
    case (state)
      RS_IDLE: begin
        if (start) begin
          dvsr_next   = den;
          rem_next    = '0;
          quo_next    = '0;
          sq_rem_next = '0;
          cnt_next    = STEP_W'(QUO_W - 1);
          if (den == '0) begin
            root_next  = INV_STD_MAX;
            state_next = RS_DONE;
          end else begin
            root_next  = '0;
            state_next = RS_DIV;
          end
        end
      end
      RS_DIV: begin
        if (shifted >= {1'b0, dvsr}) begin
          rem_next = DEN_W'(shifted - {1'b0, dvsr});
          quo_next = {quo[QUO_W-2:0], 1'b1};
        end else begin
          rem_next = shifted[DEN_W-1:0];
          quo_next = {quo[QUO_W-2:0], 1'b0};
        end
        if (cnt == '0) begin
          src_next   = {1'b0, quo_next};
          cnt_next   = STEP_W'(ROOT_W - 1);
          state_next = RS_SQRT;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      RS_SQRT: begin
        if (acc >= trial) begin
          sq_rem_next = SQ_REM_W'(acc - trial);
          root_next   = {root[ROOT_W-2:0], 1'b1};
        end else begin
          sq_rem_next = acc[SQ_REM_W-1:0];
          root_next   = {root[ROOT_W-2:0], 1'b0};
        end
        src_next = {src[SRC_W-3:0], 2'b00};
        if (cnt == '0) begin
          state_next = RS_DONE;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      RS_DONE: begin
        state_next = RS_IDLE;
      end
      default: begin
        state_next = RS_IDLE;
      end
    endcase
  end

  assign status.busy = (state != RS_IDLE);
  assign status.done = (state == RS_DONE);
  assign inv_std     = {{(DATA_W - ROOT_W){1'b0}}, root};

`ifndef ASSERT_OFF
  a_root_range: assert property (@(posedge clk) disable iff (rst)
    status.done |-> root <= INV_STD_MAX)
    else $error("inverse sqrt result above 256.0");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == RS_IDLE)
    else $error("inverse sqrt started while busy");
`endif

endmodule

// File: design/bn_param_store.sv
module bn_param_store (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [bn_pkg::CH_W-1:0] wr_addr,
  input  bn_pkg::bn_param_t       wr_data,
  input  logic                    rd_en,
  input  logic [bn_pkg::CH_W-1:0] rd_addr,
  output bn_pkg::bn_param_t       rd_data
);
  import bn_pkg::*;

  bn_param_t mem [MAX_CHANNELS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/bn_norm_pipe.sv
module bn_norm_pipe (
  input  logic                           clk,
  input  logic                           rst,
  input  bn_pkg::bn_cfg_t                cfg,
  input  logic                           take,
  input  logic [bn_pkg::CH_W-1:0]        channel_index,
  input  logic signed [bn_pkg::DATA_W-1:0] sample_value,
  output logic                           ready,
  input  bn_pkg::bn_param_t              param,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [bn_pkg::DATA_W-1:0] result_value,
  output logic [bn_pkg::CH_W-1:0]        result_channel,
  output logic                           error_code
);
  import bn_pkg::*;

  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

  logic                     s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, s6_valid;
  logic [CH_W-1:0]          s1_ch, s2_ch, s3_ch, s4_ch, s5_ch, s6_ch;
  logic                     s1_err, s2_err, s3_err, s4_err, s5_err, s6_err;
  logic signed [DATA_W-1:0] s1_x;
  logic signed [DATA_W:0]   s2_diff;
  logic [ROOT_W-1:0]        s2_inv;
  logic signed [DATA_W-1:0] s2_gamma, s3_gamma, s4_gamma;
  logic signed [DATA_W-1:0] s2_beta, s3_beta, s4_beta, s5_beta, s6_beta;
  logic signed [58:0]       s3_prod;
  logic signed [58:0]       s3_round;
  logic signed [DATA_W-1:0] s4_v, s5_v;
  logic signed [63:0]       s5_prod;
  logic signed [63:0]       s5_round;
  logic signed [47:0]       s6_v;
  logic signed [48:0]       s6_sum;

  assign rdy7  = !out_valid || !out_stall;
  assign rdy6  = !s6_valid || rdy7;
  assign rdy5  = !s5_valid || rdy6;
  assign rdy4  = !s4_valid || rdy5;
  assign rdy3  = !s3_valid || rdy4;
  assign rdy2  = !s2_valid || rdy3;
  assign rdy1  = !s1_valid || rdy2;
  assign ready = rdy1;

  assign s3_round = s3_prod + 59'sd32768;
  assign s5_round = s5_prod + 64'sd32768;
  assign s6_sum   = {s6_v[47], s6_v}
                  + (cfg.use_beta ? {{17{s6_beta[DATA_W-1]}}, s6_beta} : 49'sd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      s6_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_valid <= take;
      end
      if (rdy2) begin
        s2_valid <= s1_valid;
      end
      if (rdy3) begin
        s3_valid <= s2_valid;
      end
      if (rdy4) begin
        s4_valid <= s3_valid;
      end
      if (rdy5) begin
        s5_valid <= s4_valid;
      end
      if (rdy6) begin
        s6_valid <= s5_valid;
      end
      if (rdy7) begin
        out_valid <= s6_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_ch  <= channel_index;
      s1_x   <= sample_value;
      s1_err <= ({1'b0, channel_index} >= cfg.num_channels);
    end
    if (rdy2) begin
      s2_ch    <= s1_ch;
      s2_err   <= s1_err;
      s2_diff  <= {s1_x[DATA_W-1], s1_x} - {param.mean[DATA_W-1], param.mean};
      s2_inv   <= param.inv_std[ROOT_W-1:0];
      s2_gamma <= param.gamma;
      s2_beta  <= param.beta;
    end
    if (rdy3) begin
      s3_ch    <= s2_ch;
      s3_err   <= s2_err;
      s3_prod  <= s2_diff * $signed({1'b0, s2_inv});
      s3_gamma <= s2_gamma;
      s3_beta  <= s2_beta;
    end
    if (rdy4) begin
      s4_ch    <= s3_ch;
      s4_err   <= s3_err;
      s4_v     <= sat32({{6{s3_round[58]}}, s3_round[58:16]});
      s4_gamma <= s3_gamma;
      s4_beta  <= s3_beta;
    end
    if (rdy5) begin
      s5_ch   <= s4_ch;
      s5_err  <= s4_err;
      s5_prod <= s4_v * s4_gamma;
      s5_v    <= s4_v;
      s5_beta <= s4_beta;
    end
    if (rdy6) begin
      s6_ch   <= s5_ch;
      s6_err  <= s5_err;
      s6_v    <= cfg.use_gamma ? s5_round[63:16] : {{16{s5_v[DATA_W-1]}}, s5_v};
      s6_beta <= s5_beta;
    end
    if (rdy7) begin
      result_channel <= s6_ch;
      error_code     <= s6_err;
      result_value   <= s6_err ? 32'sd0 : sat32(s6_sum);
    end
  end

`ifndef ASSERT_OFF
  a_ok_in_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !error_code) |-> ({1'b0, result_channel} < cfg.num_channels))
    else $error("ok result for channel outside configured range");
`endif

endmodule

// File: bench/batchnorm_inference_affine_tb.sv
module batchnorm_inference_affine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bn_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [CH_W-1:0]          channel;
    logic                     err;
  } bn_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} step_kind_t;

  typedef struct packed {
    step_kind_t            kind;
    cfg_reg_t              sel;
    logic [CFG_DATA_W-1:0] cfg_val;
    logic                  cmd;
    logic [CH_W-1:0]       ch;
    logic [DATA_W-1:0]     x;
    logic [DATA_W-1:0]     mean;
    logic [DATA_W-1:0]     variance;
    logic [DATA_W-1:0]     gam;
    logic [DATA_W-1:0]     bet;
    logic                  typed;
    logic [DATA_W-1:0]     want_value;
    logic                  want_err;
  } dir_step_t;

  localparam int DIR_ROWS = 33;
  localparam int SETTLE_CYCLES = 90;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write_en = 1'b0;
  logic [CFG_INDEX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]         cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          cmd = CMD_SAMPLE;
  logic [CH_W-1:0]               channel_index = '0;
  logic signed [DATA_W-1:0]      sample_value = '0;
  logic signed [DATA_W-1:0]      load_mean = '0;
  logic [DATA_W-1:0]             load_var = '0;
  logic signed [DATA_W-1:0]      load_gamma = '0;
  logic signed [DATA_W-1:0]      load_beta = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [DATA_W-1:0]      result_value;
  logic [CH_W-1:0]               result_channel;
  logic                          error_code;

  // predictor state
  logic [NUM_CH_W-1:0] nc_cfg = 13'd1;
  logic                gamma_on = 1'b1;
  logic                beta_on = 1'b1;
  logic [EPS_W-1:0]    eps_cfg = 16'd1;
  logic [DATA_W-1:0]   mean_mem  [MAX_CHANNELS];
  logic [DATA_W-1:0]   inv_mem   [MAX_CHANNELS];
  logic [DATA_W-1:0]   gamma_mem [MAX_CHANNELS];
  logic [DATA_W-1:0]   beta_mem  [MAX_CHANNELS];
  bit                  ch_loaded [MAX_CHANNELS];

  bn_result_t  pending_results [$];
  logic        calm = 1'b0;
  int unsigned fail_count = 0;
  int unsigned loads_sent = 0;
  int unsigned samples_sent = 0;
  int unsigned range_errors = 0;
  int unsigned results_checked = 0;

  dir_step_t dir_steps [DIR_ROWS] = '{
    '{ROW_ITEM, REG_NUM_CHANNELS, 16'h0000, CMD_LOAD, 12'h000, 32'h0000_0000, 32'h0000_0000,
      32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
    '{ROW_ITEM, REG_NUM_CHANNELS, 16'h0000, CMD_SAMPLE, 12'h000, 32'h0001_0000, 32'h0,
      32'h0, 32'h0, 32'h0, 1'b1, 32'h0100_0000, 1'b0},
    '{ROW_ITEM, REG_NUM_CHANNELS, 16'h0000, CMD_SAMPLE, 12'h000, 32'h7fff_ffff, 32'h0,
      32'h0, 32'h0, 32'h0, 1'b1, 32'h7fff_ffff, 1'b0},
    '{ROW_ITEM, REG_NUM_CHANNELS, 16'h0000, CMD_SAMPLE, 12'h000, 32'h8000_0000, 32'h0,
      32'h0, 32'h0, 32'h0, 1'b1, 32'h8000_0000, 1'b0},
    '{ROW_ITEM, REG_NUM_CHANNELS, 16'h0000, CMD_SAMPLE, 12'h001, 32'h0001_2345, 32'h0,
      32'h0, 32'h0, 32'h0, 1'b1, 32'h0000_0000, 1'b1},
    '{ROW_ITEM, REG_NUM_CHANNELS, 16'h0000, CMD_SAMPLE, 12'hfff, 32'hdead_beef, 32'h0,
      32'h0, 32'h0, 32'h0, 1'b1, 32'h0000_0000, 1'b1},
    '{ROW_CFG, REG_NUM_CHANNELS, 16'h1000, CMD_SAMPLE, 12'h000, 32'h0, 32'h0,
      32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_CFG, REG_EPSILON, 16'h0000, CMD_SAMPLE, 12'h000, 32'h0, 32'h0,
      32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, REG_NUM_CHANNELS, 16'h0000, CMD_LOAD, 12'hfff, 32'h0, 32'h8000_0000,
      32'h0000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, REG_NUM_CHANNELS, 16'h0000, CMD_SAMPLE, 12'hfff, 32'h7fff_ffff, 32'h0,
      32'h0, 32'h0, 32'h0, 1'b1, 32'h7fff_ffff, 1'b0},
    '{ROW_ITEM, REG_NUM_CHANNELS, 16'h0000, CMD_SAMPLE, 12'hfff, 32'h8000_0000, 32'h0,
      32'h0, 32'h0, 32'h0, 1'b1, 32'h7fff_ffff, 1'b0},
    '{ROW_ITEM, REG_NUM_CHANNELS, 16'h0000, CMD_LOAD, 12'h555, 32'h0, 32'h7fff_ffff,
      32'hffff_ffff, 32'h8000_0000, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, REG_NUM_CHANNELS, 16'h0000, CMD_SAMPLE, 12'h555, 32'h8000_0000, 32'h0,
      32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_CFG, REG_EPSILON, 16'hffff, CMD_SAMPLE, 12'h000, 32'h0, 32'h0,
      32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_CFG, REG_USE_GAMMA, 16'h0000, CMD_SAMPLE, 12'h000, 32'h0, 32'h0,
      32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, REG_NUM_CHANNELS, 16'h0000, CMD_LOAD, 12'haaa, 32'h0, 32'h1234_5678,
      32'hffff_ffff, 32'h0000_0000, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, REG_NUM_CHANNELS, 16'h0000, CMD_SAMPLE, 12'haaa, 32'h0000_0000, 32'h0,
      32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, REG_NUM_CHANNELS, 16'h0000, CMD_SAMPLE, 12'h555, 32'h7fff_ffff, 32'h0,
      32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_CFG, REG_USE_BETA, 16'h0000, CMD_SAMPLE, 12'h000, 32'h0, 32'h0,
      32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_CFG, REG_USE_GAMMA, 16'h0001, CMD_SAMPLE, 12'h000, 32'h0, 32'h0,
      32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, REG_NUM_CHANNELS, 16'h0000, CMD_SAMPLE, 12'haaa, 32'hffff_ffff, 32'h0,
      32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, REG_NUM_CHANNELS, 16'h0000, CMD_SAMPLE, 12'h555, 32'h0000_0000, 32'h0,
      32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_CFG, REG_USE_GAMMA, 16'h0000, CMD_SAMPLE, 12'h000, 32'h0, 32'h0,
      32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, REG_NUM_CHANNELS, 16'h0000, CMD_SAMPLE, 12'h000, 32'h0001_0000, 32'h0,
      32'h0, 32'h0, 32'h0, 1'b1, 32'h0100_0000, 1'b0},
    '{ROW_ITEM, REG_NUM_CHANNELS, 16'h0000, CMD_SAMPLE, 12'h000, 32'h0000_0000, 32'h0,
      32'h0, 32'h0, 32'h0, 1'b1, 32'h0000_0000, 1'b0},
    '{ROW_CFG, REG_NUM_CHANNELS, 16'h0000, CMD_SAMPLE, 12'h000, 32'h0, 32'h0,
      32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, REG_NUM_CHANNELS, 16'h0000, CMD_SAMPLE, 12'h000, 32'h0000_7fff, 32'h0,
      32'h0, 32'h0, 32'h0, 1'b1, 32'h0000_0000, 1'b1},
    '{ROW_ITEM, REG_NUM_CHANNELS, 16'h0000, CMD_LOAD, 12'h800, 32'h0, 32'h0000_0000,
      32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0, 32'h0, 1'b0},
    '{ROW_CFG, REG_NUM_CHANNELS, 16'h1000, CMD_SAMPLE, 12'h000, 32'h0, 32'h0,
      32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_CFG, REG_USE_GAMMA, 16'h0001, CMD_SAMPLE, 12'h000, 32'h0, 32'h0,
      32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_CFG, REG_USE_BETA, 16'h0001, CMD_SAMPLE, 12'h000, 32'h0, 32'h0,
      32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_CFG, REG_EPSILON, 16'h0001, CMD_SAMPLE, 12'h000, 32'h0, 32'h0,
      32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, REG_NUM_CHANNELS, 16'h0000, CMD_SAMPLE, 12'h800, 32'h0002_0000, 32'h0,
      32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0}
  };

  batchnorm_inference_affine DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .channel_index  (channel_index),
    .sample_value   (sample_value),
    .load_mean      (load_mean),
    .load_var       (load_var),
    .load_gamma     (load_gamma),
    .load_beta      (load_beta),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_value   (result_value),
    .result_channel (result_channel),
    .error_code     (error_code)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic signed [31:0] clamp_s32(input longint v);
    if (v > longint'(32'sh7fff_ffff)) begin
      return 32'sh7fff_ffff;
    end else if (v < longint'(32'sh8000_0000)) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // largest y with y*y <= floor(2^48 / d), i.e. 1/sqrt(d) in Q16.16
  function automatic logic [31:0] inv_root(input logic [32:0] d);
    longint unsigned q;
    longint unsigned y;
    longint unsigned t;
    if (d == 0) begin
      return 32'h0100_0000;
    end
    q = (64'd1 << 48) / d;
    y = 0;
    for (int b = 24; b >= 0; b--) begin
      t = y | (64'd1 << b);
      if (t * t <= q) begin
        y = t;
      end
    end
    return y[31:0];
  endfunction

  function automatic bn_result_t predict_norm(input logic [CH_W-1:0] ch,
                                              input logic signed [31:0] x);
    bn_result_t r;
    longint     acc;
    r.channel = ch;
    r.value = '0;
    r.err = 1'b0;
    if (ch >= nc_cfg) begin
      r.err = 1'b1;
      return r;
    end
    acc = longint'(x) - longint'($signed(mean_mem[ch]));
    acc = clamp_s32((acc * longint'(inv_mem[ch]) + 32768) >>> 16);
    if (gamma_on) begin
      acc = (acc * longint'($signed(gamma_mem[ch])) + 32768) >>> 16;
    end
    if (beta_on) begin
      acc = acc + longint'($signed(beta_mem[ch]));
    end
    r.value = clamp_s32(acc);
    return r;
  endfunction

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(0, 7))
      0: return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
      1: return ($urandom_range(0, 1) != 0) ? 32'h0000_0000 : 32'hffff_ffff;
      2, 3, 4: return 32'($urandom_range(0, 32'h40000)) - 32'h20000;
      default: return $urandom();
    endcase
  endfunction

  task automatic note_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    fail_count++;
    $error("%s: expected %h, got %h", field, want, got);
  endtask

  task automatic send_item(input logic c, input logic [CH_W-1:0] ch,
                           input logic [31:0] x, mean, variance, gam, bet,
                           input logic typed, input bn_result_t typed_res);
    int unsigned gap;
    bn_result_t  r;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    channel_index <= ch;
    sample_value <= x;
    load_mean <= mean;
    load_var <= variance;
    load_gamma <= gam;
    load_beta <= bet;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (c == CMD_LOAD) begin
      mean_mem[ch] = mean;
      gamma_mem[ch] = gam;
      beta_mem[ch] = bet;
      inv_mem[ch] = inv_root(33'(variance) + 33'(eps_cfg));
      ch_loaded[ch] = 1'b1;
      loads_sent++;
    end else begin
      r = typed ? typed_res : predict_norm(ch, x);
      if (r.err) begin
        range_errors++;
      end
      pending_results.push_back(r);
      samples_sent++;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] val);
    cfg_write_en <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    @(posedge clk);
    case (sel)
      REG_NUM_CHANNELS: nc_cfg = val[NUM_CH_W-1:0];
      REG_USE_GAMMA:    gamma_on = val[0];
      REG_USE_BETA:     beta_on = val[0];
      REG_EPSILON:      eps_cfg = val[EPS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic run_phase(input logic [NUM_CH_W-1:0] nc, input logic g, b,
                           input logic [EPS_W-1:0] eps, input int unsigned n_items);
    int unsigned       pick;
    int unsigned       top;
    int unsigned       live [$];
    logic [CH_W-1:0]   ch;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] variance;
    logic [DATA_W-1:0] gam;
    settle();
    write_reg(REG_NUM_CHANNELS, 16'(nc));
    write_reg(REG_USE_GAMMA, 16'(g));
    write_reg(REG_USE_BETA, 16'(b));
    write_reg(REG_EPSILON, eps);
    cfg_write_en <= 1'b0;
    top = (nc > MAX_CHANNELS) ? MAX_CHANNELS : nc;
    for (int c = 0; c < top; c++) begin
      if (ch_loaded[c]) begin
        live.push_back(c);
      end
    end
    for (int unsigned i = 0; i < n_items; i++) begin
      calm = (i >= n_items / 3) && (i < n_items / 3 + 30);
      if (i % 97 == 96) begin
        drain();
      end
      pick = $urandom_range(0, 99);
      if (pick < 18 || (top != 0 && live.size() == 0)) begin
        if (top != 0 && $urandom_range(0, 3) != 0) begin
          ch = CH_W'($urandom_range(0, top - 1));
        end else begin
          ch = CH_W'($urandom_range(0, MAX_CHANNELS - 1));
        end
        if (ch < top && !ch_loaded[ch]) begin
          live.push_back(ch);
        end
        case ($urandom_range(0, 3))
          0: variance = $urandom_range(0, 3);
          1: variance = $urandom_range(0, 32'h40000);
          default: variance = $urandom();
        endcase
        gam = ($urandom_range(0, 1) != 0) ?
              32'($urandom_range(0, 32'h30000)) - 32'h18000 : rand_q16();
        send_item(CMD_LOAD, ch, rand_q16(), rand_q16(), variance, gam, rand_q16(),
                  1'b0, '0);
      end else if (top < MAX_CHANNELS && (pick < 30 || live.size() == 0)) begin
        ch = CH_W'($urandom_range(top, MAX_CHANNELS - 1));
        send_item(CMD_SAMPLE, ch, rand_q16(), rand_q16(), $urandom(), rand_q16(),
                  rand_q16(), 1'b0, '0);
      end else begin
        ch = CH_W'(live[$urandom_range(0, live.size() - 1)]);
        x = ($urandom_range(0, 1) != 0) ?
            mean_mem[ch] + 32'($urandom_range(0, 32'h8000)) - 32'h4000 : rand_q16();
        send_item(CMD_SAMPLE, ch, x, rand_q16(), $urandom(), rand_q16(), rand_q16(),
                  1'b0, '0);
      end
    end
    calm = 1'b0;
  endtask

  // result side: random stall before each transaction
  initial begin : result_sink
    int unsigned hold;
    while (rst) @(posedge clk);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 7);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : result_check
    bn_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result_value", 32'h0, result_value);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (result_value !== want.value) begin
          note_mismatch("result_value", want.value, result_value);
        end
        if (result_channel !== want.channel) begin
          note_mismatch("result_channel", 32'(want.channel), 32'(result_channel));
        end
        if (error_code !== want.err) begin
          note_mismatch("error_code", 32'(want.err), 32'(error_code));
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_steps[i].kind == ROW_CFG) begin
        if (i == 0 || dir_steps[i-1].kind != ROW_CFG) begin
          settle();
        end
        write_reg(dir_steps[i].sel, dir_steps[i].cfg_val);
        if (i == DIR_ROWS - 1 || dir_steps[i+1].kind != ROW_CFG) begin
          cfg_write_en <= 1'b0;
        end
      end else begin
        send_item(dir_steps[i].cmd, dir_steps[i].ch, dir_steps[i].x, dir_steps[i].mean,
                  dir_steps[i].variance, dir_steps[i].gam, dir_steps[i].bet,
                  dir_steps[i].typed,
                  '{dir_steps[i].want_value, dir_steps[i].ch, dir_steps[i].want_err});
      end
    end

    run_phase(13'd4096, 1'b1, 1'b1, 16'd1, 230);
    run_phase(13'd64, 1'b1, 1'b0, 16'd0, 210);
    run_phase(13'd4096, 1'b0, 1'b1, 16'hffff, 230);
    run_phase(13'd1, 1'b1, 1'b1, 16'd0, 150);
    run_phase(13'd0, 1'b1, 1'b1, 16'd1, 50);
    run_phase(13'd300, 1'b0, 1'b0, 16'h1234, 230);
    run_phase(13'd4096, 1'b1, 1'b1, 16'($urandom_range(0, 65535)), 330);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Sent %0d transactions: %0d parameter loads, %0d samples (%0d out of range).",
             loads_sent + samples_sent, loads_sent, samples_sent, range_errors);
    $display("Compared %0d results over seven register settings plus the directed set.",
             results_checked);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
